[src/hfd_pkg.sv]
// ----------------------------------------------------------------------------
// hfd_pkg
// shared types and constants of the huffman tree bit decoder
// ----------------------------------------------------------------------------
package hfd_pkg;

  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int CODE_BITS = 8;
  localparam int CNT_W     = $clog2(CODE_BITS);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // one tree node as stored in the node table
  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  // node table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    node_t            node;
  } wr_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH,
    ST_FLUSH
  } st_t;

endpackage

[src/hfd_node_mem.sv]
// ----------------------------------------------------------------------------
// hfd_node_mem
// node table: one write port, two registered read ports
// ----------------------------------------------------------------------------
module hfd_node_mem
  import hfd_pkg::*;
#(
  parameter int NODES = 512
) (
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [IDX_W-1:0] addr_a,
  input  logic [IDX_W-1:0] addr_b,
  output node_t            rd_a,
  output node_t            rd_b
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  node_t mem [NODES];
  node_t data_a;
  node_t data_b;
  logic  oob_a;
  logic  oob_b;

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.idx) < NODES)) begin
      mem[AW'(wr.idx)] <= wr.node;
    end
  end

  // indexes beyond the table read as an all-zero node
  always_ff @(posedge clk) begin
    data_a <= mem[AW'(addr_a)];
    data_b <= mem[AW'(addr_b)];
    oob_a  <= !(32'(addr_a) < NODES);
    oob_b  <= !(32'(addr_b) < NODES);
  end

  assign rd_a = oob_a ? '0 : data_a;
  assign rd_b = oob_b ? '0 : data_b;

endmodule

[src/hfd_walk_ctrl.sv]
// ----------------------------------------------------------------------------
// hfd_walk_ctrl
// request control and tree walk, one node table read per code bit
// ----------------------------------------------------------------------------
module hfd_walk_ctrl
  import hfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  logic [IDX_W-1:0] node_index,
  input  logic [IDX_W-1:0] left_child,
  input  logic [IDX_W-1:0] right_child,
  input  logic             is_leaf,
  input  logic [SYM_W-1:0] leaf_symbol,
  input  logic [7:0]       code_byte,
  input  logic [IDX_W-1:0] root_index,
  input  node_t            rd_a,
  input  node_t            rd_b,
  output logic [IDX_W-1:0] addr_a,
  output wr_req_t          wr,
  output logic             busy,
  output logic             result_valid,
  output logic [SYM_W-1:0] symbol,
  output logic             last
);

  st_t                  state;
  st_t                  state_next;
  logic [CNT_W-1:0]     bit_cnt;
  logic [CODE_BITS-1:0] code_sr;
  logic [IDX_W-1:0]     cur_idx;
  logic                 pend_valid;
  logic [SYM_W-1:0]     pend_sym;

  logic                 accept;
  logic                 hit_leaf;
  node_t                base;
  logic [IDX_W-1:0]     child;
  logic                 emit;
  logic [SYM_W-1:0]     emit_sym;
  logic                 emit_last;
  logic                 pend_valid_next;
  logic [SYM_W-1:0]     pend_sym_next;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // rd_a holds the node reached by the previous bit, except on the first bit
  assign hit_leaf = rd_a.leaf &&
                    (((state == ST_WALK) && (bit_cnt != '0)) || (state == ST_FINISH));
  assign base     = hit_leaf ? rd_b : rd_a;
  assign child    = code_sr[CODE_BITS-1] ? base.right : base.left;
  assign addr_a   = (state == ST_WALK) ? child : cur_idx;

  always_comb begin
    wr.en   = accept && (op == OP_LOAD);
    wr.idx  = node_index;
    wr.node = '{left: left_child, right: right_child, leaf: is_leaf, sym: leaf_symbol};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_DECODE)) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (bit_cnt == CNT_W'(CODE_BITS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = (hit_leaf && pend_valid) ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // a symbol waits in pend until the next leaf or the end of the byte tells last
  always_comb begin
    emit            = 1'b0;
    emit_sym        = pend_sym;
    emit_last       = 1'b0;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    case (state)
      ST_WALK: begin
        if (hit_leaf) begin
          emit            = pend_valid;
          pend_valid_next = 1'b1;
          pend_sym_next   = rd_a.sym;
        end
      end
      ST_FINISH: begin
        if (hit_leaf) begin
          if (pend_valid) begin
            emit          = 1'b1;
            pend_sym_next = rd_a.sym;
          end else begin
            emit      = 1'b1;
            emit_sym  = rd_a.sym;
            emit_last = 1'b1;
            pend_valid_next = 1'b0;
          end
        end else begin
          emit            = pend_valid;
          emit_last       = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      ST_FLUSH: begin
        emit            = 1'b1;
        emit_last       = 1'b1;
        pend_valid_next = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bit_cnt      <= '0;
      cur_idx      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend_valid   <= pend_valid_next;
      result_valid <= emit;
      if (accept) begin
        bit_cnt <= '0;
      end else if (state == ST_WALK) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
      if (state == ST_WALK) begin
        cur_idx <= child;
      end else if ((state == ST_FINISH) && hit_leaf) begin
        cur_idx <= root_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_sym <= pend_sym_next;
    symbol   <= emit_sym;
    last     <= emit_last;
    if (accept) begin
      code_sr <= code_byte;
    end else if (state == ST_WALK) begin
      code_sr <= {code_sr[CODE_BITS-2:0], 1'b0};
    end
  end

  a_decode_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_DECODE)) |=> (state == ST_WALK) && (bit_cnt == '0))
    else $error("decode request did not start the walk");

  a_flush_has_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> pend_valid)
    else $error("flush without a held symbol");

  a_last_ends_byte: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (state == ST_IDLE) && !pend_valid)
    else $error("last symbol while the byte is still in work");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) != ST_IDLE))
    else $error("result out of an idle cycle");

endmodule

[src/huffman_tree_bit_decoder_unit.sv]
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder_unit
// huffman decoder walking a node table, one code bit per cycle
// ----------------------------------------------------------------------------
// usage:
//   a request is taken when start is high and busy is low. op selects a
//   node load (node_index, left_child, right_child, is_leaf, leaf_symbol)
//   or the decode of one code_byte, bits taken msb first.
//   a load leaves busy low, so loads go back to back.
//   a decode keeps busy high while it walks the eight code bits, one
//   dependent node table read per bit, and then tests the node reached by
//   the last bit; a flush step follows when a leaf is reached on the eighth
//   bit while an earlier symbol of the byte still waits.
//   each decoded symbol shows on symbol for one cycle with result_valid;
//   last marks the final symbol of the byte. the receiver cannot stall,
//   so results are simply presented. a byte that reaches no leaf gives none.
//   root_we/root_data write the root index; the user must do so only while busy is low,
//   the block does not enforce it. reset clears the walk position and the root index
//   to node 0; the node table keeps no reset and must be loaded before it is walked.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_unit
  import hfd_pkg::*;
#(
  parameter int NODES = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [IDX_W-1:0] node_index,
  input  logic [IDX_W-1:0] left_child,
  input  logic [IDX_W-1:0] right_child,
  input  logic             is_leaf,
  input  logic [SYM_W-1:0] leaf_symbol,
  input  logic [7:0]       code_byte,
  input  logic             root_we,
  input  logic [IDX_W-1:0] root_data,
  output logic             result_valid,
  output logic [SYM_W-1:0] symbol,
  output logic             last
);

  // root index register; the user must write it only between requests, the block itself does not enforce it
  logic [IDX_W-1:0] root_index;

  // node table ports
  wr_req_t          wr;
  logic [IDX_W-1:0] addr_a;
  node_t            rd_a;
  node_t            rd_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_index <= '0;
    end else if (root_we) begin
      root_index <= root_data;
    end
  end

  // port a follows the walk, port b keeps the root node at hand so a walk
  // can restart from the root in the same cycle that it meets a leaf
  hfd_node_mem #(
    .NODES (NODES)
  ) u_mem (
    .clk    (clk),
    .wr     (wr),
    .addr_a (addr_a),
    .addr_b (root_index),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  // request handling, bit walk and result sequencing
  hfd_walk_ctrl u_walk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .node_index   (node_index),
    .left_child   (left_child),
    .right_child  (right_child),
    .is_leaf      (is_leaf),
    .leaf_symbol  (leaf_symbol),
    .code_byte    (code_byte),
    .root_index   (root_index),
    .rd_a         (rd_a),
    .rd_b         (rd_b),
    .addr_a       (addr_a),
    .wr           (wr),
    .busy         (busy),
    .result_valid (result_valid),
    .symbol       (symbol),
    .last         (last)
  );

endmodule
